// ----- design/sha_pkg.sv -----
package sha_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } sha_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } sha_state_t;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

endpackage

// ----- design/sha256_stream_hasher.sv -----
// SHA-256 hasher taking one message byte per word; a finish word pads the message and
// then yields the digest as eight 32-bit words, most significant first, after which the
// block starts a new message. A four-entry input queue absorbs bytes while the engine is
// busy. Every 64th byte starts a compression of 64 rounds, one round per cycle, followed
// by an update step that folds the result into the chaining words. A finish word runs one
// such compression, or two when 56 or more bytes are pending, and then emits eight digest
// words at one per cycle while out_stall is low.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  logic      q_valid, q_pop;
  sha_item_t q_item;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_data_byte,
    .q_valid, .q_pop, .q_item
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item,
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );

endmodule

// ----- design/sha_front.sv -----
module sha_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [7:0]          in_data_byte,
  output logic                q_valid,
  input  logic                q_pop,
  output sha_pkg::sha_item_t  q_item
);
  import sha_pkg::*;

  localparam int unsigned AW = $clog2(QueueDepth);

  sha_item_t        mem_r [QueueDepth];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             push;

  assign in_stall = (cnt_r == (AW+1)'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{req_type: in_req_type, data_byte: in_data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

endmodule

// ----- design/sha_back.sv -----
module sha_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  sha_pkg::sha_item_t  q_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_word
);
  import sha_pkg::*;

  sha_state_t   state_r, state_nxt;
  logic [31:0]  hash_r [8];
  logic [31:0]  var_r [8];
  logic [31:0]  w_r [16];
  logic [31:0]  blk_r [16];
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic [5:0]   round_r;
  logic         fin_r;
  logic         second_r;
  logic [2:0]   idx_r;

  logic [31:0]  w_cur, w15, w2, s0, s1, t1, t2, blk_w;
  logic [5:0]   r;
  logic [63:0]  total;
  logic [31:0]  pad_word [16];
  logic         start_compress;

  assign r     = round_r;
  assign total = bits_r + {55'd0, fill_r, 3'd0};
  assign blk_w = blk_r[r[3:0]];
  assign w15   = w_r[4'(r - 6'd15)];
  assign w2    = w_r[4'(r - 6'd2)];
  assign s0    = rotr(w15, 5'd7) ^ rotr(w15, 5'd18) ^ (w15 >> 3);
  assign s1    = rotr(w2, 5'd17) ^ rotr(w2, 5'd19) ^ (w2 >> 10);
  assign w_cur = (r < 6'd16) ? blk_w : w_r[r[3:0]] + s0 + w_r[4'(r - 6'd7)] + s1;
  assign t1 = var_r[7] + (rotr(var_r[4], 5'd6) ^ rotr(var_r[4], 5'd11) ^ rotr(var_r[4], 5'd25))
            + ((var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6])) + ROUND_K[r] + w_cur;
  assign t2 = (rotr(var_r[0], 5'd2) ^ rotr(var_r[0], 5'd13) ^ rotr(var_r[0], 5'd22))
            + ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]));

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      for (int k = 0; k < 4; k++) begin
        if ((4*j + k) < fill_r) pad_word[j][31-8*k -: 8] = blk_r[j][31-8*k -: 8];
        else if ((4*j + k) == fill_r) pad_word[j][31-8*k -: 8] = 8'h80;
        else pad_word[j][31-8*k -: 8] = 8'h00;
      end
    end
    if (fill_r < 6'd56) begin
      pad_word[14] = total[63:32];
      pad_word[15] = total[31:0];
    end
  end

  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = hash_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  always_comb begin
    state_nxt      = state_r;
    q_pop          = 1'b0;
    start_compress = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.req_type || fill_r == 6'd63) begin
            start_compress = 1'b1;
            state_nxt      = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        if (round_r == 6'd63) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (second_r) state_nxt = ST_ROUND;
        else if (fin_r) state_nxt = ST_EMIT;
        else state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_stall && idx_r == 3'd7) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      bits_r   <= '0;
      round_r  <= '0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      idx_r    <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= INIT_HASH[i];
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          round_r <= '0;
          if (q_pop) begin
            if (!q_item.req_type) begin
              fill_r <= fill_r + 1'b1;
              fin_r  <= 1'b0;
              second_r <= 1'b0;
              if (fill_r == 6'd63) bits_r <= bits_r + 64'd512;
            end else begin
              fin_r    <= 1'b1;
              second_r <= (fill_r >= 6'd56);
            end
          end
        end
        ST_ROUND: round_r <= round_r + 1'b1;
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + var_r[i];
          round_r  <= '0;
          second_r <= 1'b0;
          idx_r    <= '0;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            idx_r <= idx_r + 1'b1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_r[i] <= INIT_HASH[i];
              fill_r <= '0;
              bits_r <= '0;
              fin_r  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_pop) begin
      if (!q_item.req_type) begin
        blk_r[fill_r[5:2]][{~fill_r[1:0], 3'd0} +: 8] <= q_item.data_byte;
      end else begin
        for (int i = 0; i < 16; i++) blk_r[i] <= pad_word[i];
      end
    end
    if (state_r == ST_UPDATE && second_r) begin
      for (int i = 0; i < 14; i++) blk_r[i] <= 32'h0;
      blk_r[14] <= total[63:32];
      blk_r[15] <= total[31:0];
    end
    if (start_compress) begin
      for (int i = 0; i < 8; i++) var_r[i] <= hash_r[i];
    end else if (state_r == ST_UPDATE && second_r) begin
      for (int i = 0; i < 8; i++) var_r[i] <= hash_r[i] + var_r[i];
    end else if (state_r == ST_ROUND) begin
      w_r[r[3:0]] <= w_cur;
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

endmodule

// ----- design/sha_checker.sv -----
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last word flag does not match index");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words not consecutive");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word))
    else $error("stalled digest word changed");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_word_index == 3'd0)
    else $error("digest does not start at word zero");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk, .rst_n, .out_valid, .out_stall,
  .out_digest_word, .out_word_index, .out_last_word
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

class digest_scoreboard;
  bit [31:0] chain [8];
  bit [7:0]  pending [64];
  int unsigned fill;
  bit [63:0] done_bits;
  bit [31:0] exp_word [$];
  bit [2:0]  exp_index [$];
  bit        exp_last [$];
  int unsigned errors;

  function new();
    restart();
    fill = 0;
    done_bits = 0;
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) chain[i] = sha_pkg::INIT_HASH[i];
    fill = 0;
    done_bits = 0;
  endfunction

  function bit [31:0] ror(bit [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    bit [31:0] w [64];
    bit [31:0] v [8];
    bit [31:0] t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {pending[4*r], pending[4*r+1], pending[4*r+2], pending[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + s0 + w[r-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function void note_word(bit req, bit [7:0] data);
    bit [63:0] total;
    if (!req) begin
      pending[fill] = data;
      fill++;
      if (fill == 64) begin
        compress();
        done_bits += 512;
        fill = 0;
      end
      return;
    end
    pending[fill] = 8'h80;
    for (int i = fill + 1; i < 64; i++) pending[i] = 0;
    if (fill >= 56) begin
      compress();
      for (int i = 0; i < 64; i++) pending[i] = 0;
    end
    total = done_bits + 64'(fill) * 8;
    for (int i = 0; i < 8; i++) pending[56+i] = total[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      exp_word.push_back(chain[i]);
      exp_index.push_back(3'(i));
      exp_last.push_back(i == 7);
    end
    restart();
  endfunction

  function void check_word(bit [31:0] word, bit [2:0] idx, bit last);
    bit [31:0] ew;
    bit [2:0]  ei;
    bit        el;
    if (exp_word.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected digest word %h index %0d", word, idx);
      return;
    end
    ew = exp_word.pop_front();
    ei = exp_index.pop_front();
    el = exp_last.pop_front();
    if (word !== ew || idx !== ei || last !== el) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected %h/%0d/%b, got %h/%0d/%b", ew, ei, el, word, idx, last);
    end
  endfunction
endclass

module tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_req_type = 0;
  logic [7:0]  in_data_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard sb = new();
  bit   sending_done = 0;
  bit   hold_off = 0;
  int   idle_cycles = 0;

  always #5 clk = ~clk;

  sha256_stream_hasher dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_req_type, in_data_byte);
      if (out_valid && !out_stall)
        sb.check_word(out_digest_word, out_word_index, out_last_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  task automatic send_word(bit req, bit [7:0] data);
    in_valid <= 1;
    in_req_type <= req;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      send_word(0, 8'($urandom));
      pause_sender();
    end
    send_word(1, 8'($urandom));
    pause_sender();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_word(1, 8'h00);
    send_word(0, 8'h00);
    send_word(0, 8'hff);
    send_word(0, 8'h5a);
    send_word(1, 8'hff);
    hold_off = 1;
    send_message(56);
    hold_off = 0;
    send_message(64);
    repeat (12) send_message($urandom_range(0, 9));
    in_valid <= 0;
    sending_done = 1;
  end

  initial begin
    int pattern;
    @(posedge rst_n);
    wait (hold_off);
    @(negedge clk);
    out_stall <= 1;
    repeat (200) @(negedge clk);
    out_stall <= 0;
    forever begin
      pattern = $urandom_range(0, 2);
      repeat ($urandom_range(5, 30)) begin
        @(negedge clk);
        out_stall <= (pattern == 0) ? 1'b0 : ($urandom_range(0, pattern) == 0);
      end
    end
  end

  initial begin
    @(posedge rst_n);
    fork
      begin
        wait (sending_done && sb.exp_word.size() == 0);
        repeat (200) @(posedge clk);
      end
      wait (idle_cycles >= 2000);
    join_any
    if (idle_cycles >= 2000) begin
      $display("simulation failed");
    end else if (sb.errors == 0 && sb.exp_word.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
